### hdl/sidec_pkg.sv
`timescale 1ns / 1ps
// Package for the signed integer to decimal ASCII converter.
// Holds the pipeline stage record and the character and divide constants; no dependencies.
package sidec_pkg;

   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned NUM_STAGES = 11;

   // Multiply by this and shift right by 35 to divide any 32-bit value by ten.
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef logic [3:0] digit_type;

   typedef struct packed {
      logic                         neg;
      logic [31:0]                  n;
      logic [63:0]                  p;
      digit_type [NUM_DIGITS-1:0]   dig;
      logic [3:0]                   ndig;
      logic                         done;
   } stage_type;

endpackage

### hdl/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Signed 32-bit integer to decimal ASCII text, one character per output beat.
// Uses sidec_pkg for the stage record and constants.
//
// Each input beat yields 1 to 11 output beats: an optional '-', then the digits
// most significant first with leading zeros dropped; rsp_last marks the final
// digit. The magnitude passes through an 11-stage pipeline (one negate stage,
// then one divide-by-ten step per stage) and lands in a character
// serializer. The serializer sets the rate: it sends a number's characters one
// after another (2 to 11 for negative values, 1 to 10 otherwise), and the next
// number is loaded in the cycle its last character leaves. When the serializer
// is busy the whole pipeline holds and req_stall is raised.
module signed_int_to_decimal_ascii
   import sidec_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_character,
   output logic               rsp_last
);

   stage_type st_ff [NUM_STAGES];
   stage_type st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;

   logic ser_valid_ff, ser_valid_in;
   logic sign_ff, sign_in;
   digit_type dig_ff [NUM_DIGITS];
   digit_type dig_in [NUM_DIGITS];
   logic [3:0] pos_ff, pos_in;

   logic pipe_adv;
   logic rsp_fire;
   logic [31:0] raw;
   logic [3:0] top_ndig;

   assign rsp_fire  = ser_valid_ff && !rsp_stall;
   assign pipe_adv  = !ser_valid_ff || (rsp_fire && rsp_last);
   assign req_stall = !pipe_adv;

   // Stage 0: sign and magnitude. The most negative value wraps to 2^31 unsigned.
   assign raw = req_value;
   always_comb begin
      st_in[0]      = '0;
      st_in[0].neg  = raw[31];
      st_in[0].n    = raw[31] ? (32'd0 - raw) : raw;
   end

   // Stage 1: first multiply by the reciprocal of ten.
   always_comb begin
      st_in[1]   = st_ff[0];
      st_in[1].p = {32'd0, st_ff[0].n} * {32'd0, RECIP_TEN};
   end

   // Stages 2 to 10: take the quotient, peel off one digit, multiply again except in the last stage.
   for (genvar k = 2; k < NUM_STAGES; k++) begin : g_div
      logic [28:0] q;
      logic [3:0]  q10;
      always_comb begin
         q   = st_ff[k-1].p[63:RECIP_SHIFT];
         // Low four bits of q*10, which is all the remainder needs.
         q10 = {q[0], 3'b000} + {q[2:0], 1'b0};
         st_in[k]            = st_ff[k-1];
         st_in[k].n          = {3'b000, q};
         st_in[k].dig[k-2]   = st_ff[k-1].n[3:0] - q10;
         if (!st_ff[k-1].done) begin
            st_in[k].ndig = 4'(k - 1);
         end
         st_in[k].done = st_ff[k-1].done || (q == 29'd0);
         if (k < NUM_STAGES - 1) begin
            st_in[k].p = {35'd0, q} * {32'd0, RECIP_TEN};
         end else begin
            st_in[k].p = '0;
         end
      end
   end

   always_comb begin
      vld_in = {vld_ff[NUM_STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // The last stage still holds the top digit as its quotient.
   assign top_ndig = st_ff[NUM_STAGES-1].done ? st_ff[NUM_STAGES-1].ndig : 4'(NUM_DIGITS);

   always_comb begin
      ser_valid_in = ser_valid_ff;
      sign_in      = sign_ff;
      pos_in       = pos_ff;
      dig_in       = dig_ff;
      if (pipe_adv) begin
         ser_valid_in = vld_ff[NUM_STAGES-1];
         sign_in      = st_ff[NUM_STAGES-1].neg;
         pos_in       = top_ndig - 4'd1;
         for (int i = 0; i < NUM_DIGITS - 1; i++) begin
            dig_in[i] = st_ff[NUM_STAGES-1].dig[i];
         end
         dig_in[NUM_DIGITS-1] = st_ff[NUM_STAGES-1].n[3:0];
      end else if (rsp_fire) begin
         if (sign_ff) begin
            sign_in = 1'b0;
         end else begin
            pos_in = pos_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_ff <= sign_in;
      pos_ff  <= pos_in;
      dig_ff  <= dig_in;
   end

   assign rsp_valid     = ser_valid_ff;
   assign rsp_character = sign_ff ? CHAR_MINUS : (CHAR_ZERO + {4'd0, dig_ff[pos_ff]});
   assign rsp_last      = !sign_ff && (pos_ff == 4'd0);

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff |-> pos_ff < 4'(NUM_DIGITS))
      else $error("digit position out of range");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff && !sign_ff |-> dig_ff[pos_ff] <= 4'd9)
      else $error("digit value above nine");

   a_lead_nonzero: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff && !sign_ff && pos_ff != 4'd0 && $past(pipe_adv)
      |-> dig_ff[pos_ff] != 4'd0)
      else $error("leading zero not suppressed");

   a_hold_when_busy: assert property (@(posedge clock) disable iff (reset)
      !pipe_adv |=> $stable(vld_ff))
      else $error("pipeline moved while the serializer was busy");

   a_sign_first: assert property (@(posedge clock) disable iff (reset)
      ser_valid_ff && !sign_ff && $past(ser_valid_ff && sign_ff && !pipe_adv)
      |-> $stable(pos_ff))
      else $error("digit position moved while the sign was pending");

endmodule

### bench/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii: directed and random integers with random idling.
// Scoreboard class predicts the decimal text per number; depends on sidec_pkg and the RTL.
module tb_signed_int_to_decimal_ascii
   import sidec_pkg::*;
();

   localparam int STALL_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_ITEMS = 111;

   // Holds the characters still owed by the block, oldest first.
   class text_scoreboard;
      logic [7:0] pending_char[$];
      logic       pending_last[$];
      int         errors     = 0;
      int         numbers    = 0;
      int         negatives  = 0;
      int         characters = 0;

      function void note_value(logic [31:0] value);
         logic [31:0] mag;
         logic [3:0]  digs [0:9];
         int          ndig;
         int          k;
         ndig = 0;
         mag = value[31] ? (32'd0 - value) : value;
         do begin
            digs[ndig] = 4'(mag % 32'd10);
            mag = mag / 32'd10;
            ndig++;
         end while (mag != 0);
         if (value[31]) begin
            pending_char.push_back(CHAR_MINUS);
            pending_last.push_back(1'b0);
            negatives++;
         end
         for (k = ndig - 1; k >= 0; k--) begin
            pending_char.push_back(CHAR_ZERO + 8'(digs[k]));
            pending_last.push_back(k == 0);
         end
         numbers++;
      endfunction

      function void check_character(logic [7:0] ch, logic last);
         logic [7:0] exp_ch;
         logic       exp_last;
         characters++;
         if (pending_char.size() == 0) begin
            $display("%0t: unexpected beat, character %h last %b", $time, ch, last);
            errors++;
         end else begin
            exp_ch = pending_char.pop_front();
            exp_last = pending_last.pop_front();
            if (ch !== exp_ch) begin
               $display("%0t: character expected %h actual %h", $time, exp_ch, ch);
               errors++;
            end
            if (last !== exp_last) begin
               $display("%0t: last expected %b actual %b", $time, exp_last, last);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return pending_char.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [7:0]         rsp_character;
   logic               rsp_last;

   text_scoreboard sb = new();
   int send_idle_pct = 32;
   int take_idle_pct = 32;
   bit want_hold = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;

   signed_int_to_decimal_ascii u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (want_hold) begin
         want_hold = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < take_idle_pct);
      end
   end

   // Both channels are observed here, and the watchdog counts cycles with no beat.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            sb.note_value(req_value);
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_character(rsp_character, rsp_last);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic send_value(input logic [31:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_value <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] value;
      int          len;
      int          i;
      int          j;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_value(32'd0);
      send_value(32'd1);
      send_value(32'hFFFF_FFFF);
      send_value(32'd9);
      send_value(32'd10);
      send_value(-32'sd10);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h8000_0001);
      send_value(32'd1000000000);
      send_value(-32'sd999999999);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'd123456789);
      send_value(-32'sd1000000000);
      send_value(32'h4000_0000);
      send_value(32'h5555_5555);
      send_value(32'hAAAA_AAAA);
      send_value(-32'sd7);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 30)
            want_hold = 1'b1;
         // A stretch with no idling on either side.
         if (i == 70) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         if (i == 105) begin
            send_idle_pct = 32;
            take_idle_pct = 32;
         end
         if ($urandom_range(0, 3) == 0) begin
            value = $urandom;
         end else begin
            // Pick a digit count first so short numbers are as common as long ones.
            len = $urandom_range(1, 10);
            lo = 32'd1;
            for (j = 1; j < len; j++)
               lo = lo * 32'd10;
            hi = (len == 10) ? 32'h7FFF_FFFF : lo * 32'd10 - 32'd1;
            if (len == 1)
               lo = 32'd0;
            value = $urandom_range(hi, lo);
            if ($urandom_range(0, 1))
               value = 32'd0 - value;
         end
         send_value(value);
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d numbers (%0d negative) into %0d characters.",
               sb.numbers, sb.negatives, sb.characters);
      $display("Covered zero, both 32-bit extremes, every digit count and a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (sb.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
